[hw/rtl/uad_pkg.sv]
package uad_pkg;

  // Default width of the internal column counter.
  localparam int COUNT_BITS_DEF = 16;

  // Width of the reported column count.
  localparam int RESULT_W = 16;

  // Byte codes that the scanner looks for.
  localparam logic [7:0] CHAR_ESC       = 8'h1B;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_THREE     = 8'h33;
  localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
  localparam logic [7:0] CSI_FINAL_LO   = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI   = 8'h7E;

  // Scanner modes: plain text, escape prefixes and the control sequence body.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_BS     = 3'd2,
    MODE_BS0    = 3'd3,
    MODE_BS03   = 3'd4,
    MODE_BS033  = 3'd5,
    MODE_CSI    = 3'd6
  } scan_mode_t;

  // One byte request as held in the input register.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } byte_req_t;

  // One finished result.
  typedef struct packed {
    logic [RESULT_W-1:0] columns;
    logic                saturated;
  } result_t;

endpackage

[hw/rtl/uad_in_reg.sv]
module uad_in_reg
  import uad_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_string,
  input  logic       advance,
  output logic       req_valid,
  output byte_req_t  req
);

  logic accept;

  // The register can take a new request whenever it is empty or draining.
  assign in_stall = req_valid & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req.text_byte     <= text_byte;
      req.end_of_string <= end_of_string;
    end
  end

endmodule

[hw/rtl/uad_scan.sv]
module uad_scan
  import uad_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  byte_req_t req,
  output result_t   result
);

  scan_mode_t            scan_mode, scan_mode_next;
  logic [1:0]            bytes_to_skip, bytes_to_skip_next;
  logic [COUNT_BITS-1:0] column_count, column_count_next;
  logic                  overflow_seen, overflow_seen_next;

  scan_mode_t            norm_mode;
  logic [1:0]            norm_skip;
  logic                  norm_add;
  scan_mode_t            mode_step;
  logic [1:0]            skip_step;
  logic [2:0]            add_step;
  logic [1:0]            pend_add;
  logic [2:0]            add_total;
  logic [COUNT_BITS:0]   sum;
  logic                  sat;
  logic [COUNT_BITS-1:0] count_sum;
  logic [7:0]            c;

  assign c = req.text_byte;

  // Plain text decode: escape starters, UTF-8 lead bytes and their tail lengths.
  always_comb begin
    norm_mode = MODE_NORMAL;
    norm_skip = 2'd0;
    norm_add  = 1'b0;
    if (c == CHAR_ESC) begin
      norm_mode = MODE_ESC;
    end else if (c == CHAR_BACKSLASH) begin
      norm_mode = MODE_BS;
    end else if (c[7] == 1'b0) begin
      norm_add = 1'b1;
    end else if (c[7:5] == 3'b110) begin
      norm_add  = 1'b1;
      norm_skip = 2'd1;
    end else if (c[7:4] == 4'b1110) begin
      norm_add  = 1'b1;
      norm_skip = 2'd2;
    end else if (c[7:3] == 5'b11110) begin
      norm_add  = 1'b1;
      norm_skip = 2'd3;
    end
  end

  // Mode transitions. A broken prefix other than a full backslash-033 counts
  // its matched bytes and then the breaking byte is decoded as plain text.
  always_comb begin
    mode_step = MODE_NORMAL;
    skip_step = 2'd0;
    add_step  = 3'd0;
    unique case (scan_mode)
      MODE_NORMAL: begin
        if (bytes_to_skip != 2'd0) begin
          skip_step = bytes_to_skip - 2'd1;
        end else begin
          mode_step = norm_mode;
          skip_step = norm_skip;
          add_step  = {2'b00, norm_add};
        end
      end
      MODE_ESC: begin
        if (c == CHAR_LBRACKET) begin
          mode_step = MODE_CSI;
        end else begin
          mode_step = norm_mode;
          skip_step = norm_skip;
          add_step  = 3'd1 + {2'b00, norm_add};
        end
      end
      MODE_BS: begin
        if (c == CHAR_ZERO) begin
          mode_step = MODE_BS0;
        end else begin
          mode_step = norm_mode;
          skip_step = norm_skip;
          add_step  = 3'd1 + {2'b00, norm_add};
        end
      end
      MODE_BS0: begin
        if (c == CHAR_THREE) begin
          mode_step = MODE_BS03;
        end else begin
          mode_step = norm_mode;
          skip_step = norm_skip;
          add_step  = 3'd2 + {2'b00, norm_add};
        end
      end
      MODE_BS03: begin
        if (c == CHAR_THREE) begin
          mode_step = MODE_BS033;
        end else begin
          mode_step = norm_mode;
          skip_step = norm_skip;
          add_step  = 3'd3 + {2'b00, norm_add};
        end
      end
      MODE_BS033: begin
        if (c == CHAR_LBRACKET) begin
          mode_step = MODE_CSI;
        end else begin
          mode_step = norm_mode;
          skip_step = norm_skip;
          add_step  = {2'b00, norm_add};
        end
      end
      MODE_CSI: begin
        if (c >= CSI_FINAL_LO && c <= CSI_FINAL_HI) begin
          mode_step = MODE_NORMAL;
        end else begin
          mode_step = MODE_CSI;
        end
      end
      default: begin
        mode_step = MODE_NORMAL;
      end
    endcase
  end

  // On the last byte a partial prefix still pending counts its bytes.
  always_comb begin
    pend_add = 2'd0;
    if (req.end_of_string) begin
      case (mode_step)
        MODE_ESC:  pend_add = 2'd1;
        MODE_BS:   pend_add = 2'd1;
        MODE_BS0:  pend_add = 2'd2;
        MODE_BS03: pend_add = 2'd3;
        default:   pend_add = 2'd0;
      endcase
    end
  end

  // Saturating add of everything this byte contributes.
  assign add_total = add_step + {1'b0, pend_add};
  assign sum       = {1'b0, column_count} + {{(COUNT_BITS-2){1'b0}}, add_total};
  assign sat       = sum[COUNT_BITS];
  assign count_sum = sat ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

  // Next state: the string end returns the scanner to its reset state.
  always_comb begin
    scan_mode_next     = scan_mode;
    bytes_to_skip_next = bytes_to_skip;
    column_count_next  = column_count;
    overflow_seen_next = overflow_seen;
    if (step) begin
      if (req.end_of_string) begin
        scan_mode_next     = MODE_NORMAL;
        bytes_to_skip_next = 2'd0;
        column_count_next  = '0;
        overflow_seen_next = 1'b0;
      end else begin
        scan_mode_next     = mode_step;
        bytes_to_skip_next = skip_step;
        column_count_next  = count_sum;
        overflow_seen_next = overflow_seen | sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_NORMAL;
      bytes_to_skip <= 2'd0;
      column_count  <= '0;
      overflow_seen <= 1'b0;
    end else begin
      scan_mode     <= scan_mode_next;
      bytes_to_skip <= bytes_to_skip_next;
      column_count  <= column_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Report the low bits of the count, zero extended for a narrow counter.
  generate
    if (COUNT_BITS >= RESULT_W) begin : g_wide
      assign result.columns = count_sum[RESULT_W-1:0];
    end else begin : g_narrow
      assign result.columns = {{(RESULT_W-COUNT_BITS){1'b0}}, count_sum};
    end
  endgenerate

  assign result.saturated = overflow_seen | sat;

endmodule

[hw/rtl/uad_out_reg.sv]
module uad_out_reg
  import uad_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  result_t             result,
  output logic                out_hold,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RESULT_W-1:0] display_columns,
  output logic                count_saturated
);

  // The register is blocked only while a result waits on a stalled receiver.
  assign out_hold = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      display_columns <= result.columns;
      count_saturated <= result.saturated;
    end
  end

endmodule

[hw/rtl/utf8_ansi_display_width_core.sv]
// Display width counter for UTF-8 text with ANSI escape sequences removed.
//
// Input channel: one byte request per accepted cycle (text_byte with
// end_of_string marking the last byte of a string) on in_valid / in_stall.
// Output channel: one request per string (display_columns, count_saturated)
// on out_valid / out_stall, issued for the byte that carries end_of_string.
//
// Throughput is one byte per cycle while no string end waits on a stalled
// receiver. A byte is held in the input register while the scanner state
// and the column counter update. A string's result and out_valid are set
// in the output register as its last byte leaves the input register.
//
// A stalled receiver holds the result in the output register. Bytes that do
// not end a string keep flowing; a string end waits in the input register
// until the output register frees, and in_stall rises while it waits.
//
// Reset (rst, synchronous) empties both registers and returns the scanner
// to plain text with a zero count.
module utf8_ansi_display_width_core
  import uad_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          text_byte,
  input  logic                end_of_string,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RESULT_W-1:0] display_columns,
  output logic                count_saturated
);

  logic      req_valid;
  byte_req_t req;
  logic      advance;
  logic      out_hold;
  result_t   result;

  // A byte moves on unless it ends a string and the result slot is blocked.
  assign advance = req_valid & (~req.end_of_string | ~out_hold);

  uad_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .end_of_string (end_of_string),
    .advance       (advance),
    .req_valid     (req_valid),
    .req           (req)
  );

  uad_scan #(
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .req    (req),
    .result (result)
  );

  uad_out_reg u_out_reg (
    .clk             (clk),
    .rst             (rst),
    .load            (advance & req.end_of_string),
    .result          (result),
    .out_hold        (out_hold),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .display_columns (display_columns),
    .count_saturated (count_saturated)
  );

endmodule

[dv/utf8_ansi_display_width_core_tb.sv]
`timescale 1ns / 100ps

module utf8_ansi_display_width_core_tb;
  import uad_pkg::*;

  // UTF-8 lead byte classes.
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_BITS = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_BITS = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_BITS = 8'hF0;

  localparam longint unsigned COL_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam int RANDOM_BYTES = 1050;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_DIRECTED = 32;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          text_byte = 8'h00;
  logic                end_of_string = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RESULT_W-1:0] display_columns;
  logic                count_saturated;

  utf8_ansi_display_width_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .end_of_string  (end_of_string),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .display_columns(display_columns),
    .count_saturated(count_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed rows; a row with fixed set carries its expected result.
  typedef struct packed {
    logic [7:0]  b;
    logic        e;
    logic        fixed;
    logic [15:0] cols;
    logic        sat;
  } dir_row_t;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // NUL alone is one column.
    '{8'h00, 1'b1, 1'b1, 16'd1, 1'b0},
    // All ones is an invalid lead and counts nothing.
    '{8'hFF, 1'b1, 1'b1, 16'd0, 1'b0},
    // Stray continuation byte, then a two-byte character.
    '{8'h80, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'h7F, 1'b1, 1'b0, 16'd0, 1'b0},
    // Three-byte character, then a four-byte one whose tail holds escape bytes.
    '{8'hE2, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_ESC, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_BACKSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_ZERO, 1'b1, 1'b0, 16'd0, 1'b0},
    // ESC not followed by a bracket, then a control sequence ending on 0x7E.
    '{CHAR_ESC, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_ESC, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CSI_FINAL_HI, 1'b1, 1'b0, 16'd0, 1'b0},
    // Literal backslash-033 sequence ending on 0x40.
    '{CHAR_BACKSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_ZERO, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_THREE, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_THREE, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CSI_FINAL_LO, 1'b1, 1'b0, 16'd0, 1'b0},
    // Bare literal escape, then a backslash prefix cut by the string end.
    '{CHAR_BACKSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_ZERO, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_THREE, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_THREE, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_BACKSLASH, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_ZERO, 1'b1, 1'b0, 16'd0, 1'b0},
    // Control sequence still open at the string end.
    '{CHAR_ESC, 1'b0, 1'b0, 16'd0, 1'b0},
    '{CHAR_LBRACKET, 1'b0, 1'b0, 16'd0, 1'b0},
    '{8'h31, 1'b1, 1'b0, 16'd0, 1'b0}
  };

  // Column counter state mirrored from the scanner.
  scan_mode_t                col_mode = MODE_NORMAL;
  logic [1:0]                tail_left = 2'd0;
  logic [COUNT_BITS_DEF-1:0] col_total = '0;
  logic                      col_clipped = 1'b0;
  result_t                   expected_widths [$];

  int   failures = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  logic [7:0] str_bytes [$];

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    failures++;
  endtask

  // Add columns, holding at the counter maximum.
  function automatic void count_cols(input int unsigned n);
    longint unsigned sum;
    sum = longint'(col_total) + longint'(n);
    if (sum > COL_MAX) begin
      col_total = '1;
      col_clipped = 1'b1;
    end else begin
      col_total = sum[COUNT_BITS_DEF-1:0];
    end
  endfunction

  // A byte in plain text with no UTF-8 tail pending.
  function automatic void text_step(input logic [7:0] c);
    if (c == CHAR_ESC) begin
      col_mode = MODE_ESC;
    end else if (c == CHAR_BACKSLASH) begin
      col_mode = MODE_BS;
    end else if (!c[7]) begin
      count_cols(1);
    end else if ((c & LEAD2_MASK) == LEAD2_BITS) begin
      count_cols(1);
      tail_left = 2'd1;
    end else if ((c & LEAD3_MASK) == LEAD3_BITS) begin
      count_cols(1);
      tail_left = 2'd2;
    end else if ((c & LEAD4_MASK) == LEAD4_BITS) begin
      count_cols(1);
      tail_left = 2'd3;
    end
  endfunction

  // A prefix that failed to match counts its bytes; c is then plain text.
  function automatic void abandon_prefix(input int unsigned matched, input logic [7:0] c);
    count_cols(matched);
    col_mode = MODE_NORMAL;
    text_step(c);
  endfunction

  function automatic void width_step(input logic [7:0] c);
    case (col_mode)
      MODE_ESC: begin
        if (c == CHAR_LBRACKET) col_mode = MODE_CSI;
        else abandon_prefix(1, c);
      end
      MODE_BS: begin
        if (c == CHAR_ZERO) col_mode = MODE_BS0;
        else abandon_prefix(1, c);
      end
      MODE_BS0: begin
        if (c == CHAR_THREE) col_mode = MODE_BS03;
        else abandon_prefix(2, c);
      end
      MODE_BS03: begin
        if (c == CHAR_THREE) col_mode = MODE_BS033;
        else abandon_prefix(3, c);
      end
      MODE_BS033: begin
        if (c == CHAR_LBRACKET) begin
          col_mode = MODE_CSI;
        end else begin
          col_mode = MODE_NORMAL;
          text_step(c);
        end
      end
      MODE_CSI: begin
        if (c >= CSI_FINAL_LO && c <= CSI_FINAL_HI) col_mode = MODE_NORMAL;
      end
      default: begin
        col_mode = MODE_NORMAL;
        if (tail_left != 2'd0) tail_left = tail_left - 2'd1;
        else text_step(c);
      end
    endcase
  endfunction

  // Close the string: count a pending prefix, queue the width, clear state.
  function automatic void finish_string(input logic fixed, input logic [15:0] fcols,
                                        input logic fsat);
    result_t want;
    case (col_mode) inside
      MODE_ESC, MODE_BS: count_cols(1);
      MODE_BS0:          count_cols(2);
      MODE_BS03:         count_cols(3);
      default: ;
    endcase
    want.columns   = col_total[RESULT_W-1:0];
    want.saturated = col_clipped;
    if (fixed) begin
      want.columns   = fcols;
      want.saturated = fsat;
    end
    expected_widths = {expected_widths, want};
    col_mode    = MODE_NORMAL;
    tail_left   = 2'd0;
    col_total   = '0;
    col_clipped = 1'b0;
  endfunction

  // Send one byte request; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic e, input logic fixed = 1'b0,
                           input logic [15:0] fcols = 16'd0, input logic fsat = 1'b0);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    burst_left--;
    in_valid      <= 1'b1;
    text_byte     <= b;
    end_of_string <= e;
    do @(posedge clk); while (in_stall);
    width_step(b);
    if (e) finish_string(fixed, fcols, fsat);
    @(negedge clk);
  endtask

  // Add one byte to the end of the string being built.
  function automatic void append_byte(input logic [7:0] b);
    str_bytes = {str_bytes, b};
  endfunction

  function automatic logic [7:0] tail_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  // Parameter bytes and a final byte of a control sequence.
  function automatic void add_csi_body();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) append_byte(8'($urandom_range(8'h20, 8'h3F)));
    append_byte(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
  endfunction

  function automatic void add_literal_escape();
    append_byte(CHAR_BACKSLASH);
    append_byte(CHAR_ZERO);
    append_byte(CHAR_THREE);
    append_byte(CHAR_THREE);
  endfunction

  // Append one random token: text, a character, a sequence or noise.
  function automatic void add_token();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    case (kind)
      0: append_byte(8'($urandom_range(8'h20, 8'h7E)));
      1: append_byte(8'($urandom_range(0, 127)));
      2: begin
        append_byte({3'b110, 5'($urandom)});
        append_byte(tail_byte());
      end
      3: begin
        append_byte({4'b1110, 4'($urandom)});
        repeat (2) append_byte(tail_byte());
      end
      4: begin
        append_byte({5'b11110, 3'($urandom)});
        repeat (3) append_byte(tail_byte());
      end
      5: begin
        append_byte(CHAR_ESC);
        append_byte(CHAR_LBRACKET);
        add_csi_body();
      end
      6: begin
        add_literal_escape();
        append_byte(CHAR_LBRACKET);
        add_csi_body();
      end
      7: add_literal_escape();
      8: begin
        // Prefix broken by an arbitrary byte.
        if ($urandom_range(0, 1) == 0) begin
          append_byte(CHAR_ESC);
        end else begin
          n = $urandom_range(1, 3);
          append_byte(CHAR_BACKSLASH);
          if (n > 1) append_byte(CHAR_ZERO);
          if (n > 2) append_byte(CHAR_THREE);
        end
        append_byte(8'($urandom));
      end
      default: append_byte(8'($urandom));
    endcase
  endfunction

  // Receiver stall pattern: calm, choppy and long-hold stretches.
  int stall_mode = 0;
  int stall_mode_left = 0;
  int stall_hold = 0;

  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      <= $urandom_range(0, 2);
      stall_mode_left <= $urandom_range(50, 300);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_hold <= $urandom_range(1, 12);
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  // Compare each accepted result with the oldest expected width.
  always @(posedge clk) begin : width_check
    result_t want;
    if (!rst && out_fire) begin
      if (expected_widths.size() == 0) begin
        flag_error($sformatf("unexpected result columns=%0d saturated=%0b",
                             display_columns, count_saturated));
      end else begin
        want = expected_widths.pop_front();
        if (display_columns !== want.columns)
          flag_error($sformatf("display_columns got %0d expected %0d",
                               display_columns, want.columns));
        if (count_saturated !== want.saturated)
          flag_error($sformatf("count_saturated got %0b expected %0b",
                               count_saturated, want.saturated));
      end
    end
  end

  // Stop the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int ntok;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_byte(directed_rows[i].b, directed_rows[i].e, directed_rows[i].fixed,
                directed_rows[i].cols, directed_rows[i].sat);

    // Random strings built from tokens, some cut short before the end.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      str_bytes.delete();
      ntok = $urandom_range(1, 8);
      for (int t = 0; t < ntok; t++) add_token();
      if ($urandom_range(0, 5) == 0 && str_bytes.size() > 1) void'(str_bytes.pop_back());
      if ($urandom_range(0, 9) == 0 && str_bytes.size() > 1) void'(str_bytes.pop_back());
      for (int i = 0; i < str_bytes.size(); i++)
        send_byte(str_bytes[i], i == str_bytes.size() - 1);
      sent += str_bytes.size();
    end
    in_valid <= 1'b0;

    // Drain outstanding widths, then watch for strays.
    while (expected_widths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
